### rtl/core/gccm_pkg.sv
// Shared types and constants for the greedy character-class sequence matcher.
// No dependencies; imported by every module of the block.
`default_nettype none

package gccm_pkg;

  // Beat kinds carried on in_tuser
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_CHAR  = 2'd2,
    ACT_END   = 2'd3
  } action_t;

  // Register indexes on the configuration port
  localparam logic REG_ELEMENT_COUNT = 1'b0;
  localparam logic REG_REPEAT_MASK   = 1'b1;

  // Fixed result field widths
  localparam int OUT_LEN_W  = 16;
  localparam int CHAR_W     = 8;
  localparam int ROW_DEPTH  = 256;

  // Decision from the sequencer stage
  typedef struct packed {
    logic                 emit;
    logic                 matched;
    logic [OUT_LEN_W-1:0] length;
  } seq_res_t;

endpackage

`default_nettype wire

### rtl/core/gccm_cfg.sv
// APB register file: element count (clamped) and repeat mask.
// Depends on gccm_pkg for register indexes.
`default_nettype none

module gccm_cfg import gccm_pkg::*; #(
  parameter int MAX_ELEMENTS = 16,
  parameter int PW = $clog2(MAX_ELEMENTS + 1),
  parameter int DW = (MAX_ELEMENTS > 32) ? 64 : 32,
  parameter int AW = (MAX_ELEMENTS > 32) ? 4 : 3
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [AW-1:0]           paddr,
  input  wire logic [DW-1:0]           pwdata,
  output logic      [DW-1:0]           prdata,
  output logic      [PW-1:0]           elem_count,
  output logic      [MAX_ELEMENTS-1:0] repeat_mask
);

  localparam int SH = AW - 1;

  logic [PW-1:0]           count_r;
  logic [MAX_ELEMENTS-1:0] rep_r;
  logic                    reg_idx;
  logic                    wr_en;

  assign reg_idx = paddr[SH];
  assign wr_en   = psel & penable & pwrite;

  // register writes; count clamps to the element capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rep_r   <= '0;
    end else if (wr_en) begin
      if (reg_idx == REG_ELEMENT_COUNT) begin
        if (pwdata > DW'(MAX_ELEMENTS)) begin
          count_r <= PW'(MAX_ELEMENTS);
        end else begin
          count_r <= pwdata[PW-1:0];
        end
      end else begin
        rep_r <= pwdata[MAX_ELEMENTS-1:0];
      end
    end
  end

  // read back
  always_comb begin
    if (reg_idx == REG_REPEAT_MASK) begin
      prdata = DW'(rep_r);
    end else begin
      prdata = DW'(count_r);
    end
  end

  assign elem_count  = count_r;
  assign repeat_mask = rep_r;

endmodule

`default_nettype wire

### rtl/core/gccm_class_mem.sv
// Class-row memory: one row per character code, registered read, valid bits.
// Depends on gccm_pkg for the row depth and character width.
`default_nettype none

module gccm_class_mem import gccm_pkg::*; #(
  parameter int MAX_ELEMENTS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    rd_en,
  input  wire logic                    wr_en,
  input  wire logic [CHAR_W-1:0]       addr,
  input  wire logic [MAX_ELEMENTS-1:0] wdata,
  output logic      [MAX_ELEMENTS-1:0] row
);

  logic [MAX_ELEMENTS-1:0] mem [ROW_DEPTH];
  logic [ROW_DEPTH-1:0]    valid_r;
  logic [MAX_ELEMENTS-1:0] rdata_r;
  logic                    rd_vld_r;

  // storage array, one port: write on loads, registered read per beat
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  // valid bits stand in for the all-zero reset contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[addr];
      end
    end
  end

  assign row = rd_vld_r ? rdata_r : '0;

endmodule

`default_nettype wire

### rtl/core/gccm_seq.sv
// Match sequencer: element pointer, consumed count and decided flag,
// updated once per beat from the class row. Depends on gccm_pkg.
`default_nettype none

module gccm_seq import gccm_pkg::*; #(
  parameter int MAX_ELEMENTS = 16,
  parameter int LENGTH_BITS  = 16,
  parameter int PW = $clog2(MAX_ELEMENTS + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    step,
  input  wire action_t                 action,
  input  wire logic [MAX_ELEMENTS-1:0] row,
  input  wire logic [PW-1:0]           elem_count,
  input  wire logic [MAX_ELEMENTS-1:0] repeat_mask,
  output seq_res_t                     res
);

  localparam int IW = $clog2(MAX_ELEMENTS);

  logic [PW-1:0]           ptr_r, ptr_nxt;
  logic [LENGTH_BITS-1:0]  cnt_r, cnt_nxt, cnt_inc, cnt_sel;
  logic                    dec_r, dec_nxt;
  logic [MAX_ELEMENTS-1:0] in_range, cand;
  logic                    found;
  logic [IW-1:0]           fidx;
  logic [PW-1:0]           fidx_next;
  logic                    end_fail;
  logic [OUT_LEN_W-1:0]    len_out;
  logic                    res_emit;
  logic                    res_match;

  // elements still ahead, and which of them stop the skip
  always_comb begin
    for (int e = 0; e < MAX_ELEMENTS; e++) begin
      in_range[e] = (PW'(e) >= ptr_r) && (PW'(e) < elem_count);
      cand[e]     = in_range[e] && !(repeat_mask[e] && !row[e]);
    end
  end

  // first stopping element: priority encode from the low end
  always_comb begin
    found = 1'b0;
    fidx  = '0;
    for (int e = MAX_ELEMENTS - 1; e >= 0; e--) begin
      if (cand[e]) begin
        found = 1'b1;
        fidx  = IW'(e);
      end
    end
  end

  assign fidx_next = PW'(fidx) + PW'(1);
  assign end_fail  = |(in_range & ~repeat_mask);
  assign cnt_inc   = (&cnt_r) ? cnt_r : cnt_r + LENGTH_BITS'(1);

  // next state and decision
  always_comb begin
    ptr_nxt   = ptr_r;
    cnt_nxt   = cnt_r;
    dec_nxt   = dec_r;
    cnt_sel   = cnt_r;
    res_emit  = 1'b0;
    res_match = 1'b0;
    case (action)
      ACT_START: begin
        ptr_nxt = '0;
        cnt_nxt = '0;
        dec_nxt = 1'b0;
      end
      ACT_CHAR: begin
        if (!dec_r) begin
          if (!found) begin
            res_emit  = 1'b1;
            res_match = 1'b1;
          end else if (repeat_mask[fidx]) begin
            ptr_nxt = PW'(fidx);
            cnt_nxt = cnt_inc;
          end else if (row[fidx]) begin
            ptr_nxt = fidx_next;
            cnt_nxt = cnt_inc;
            if (fidx_next >= elem_count) begin
              res_emit  = 1'b1;
              res_match = 1'b1;
              cnt_sel   = cnt_inc;
            end
          end else begin
            res_emit = 1'b1;
          end
        end
      end
      ACT_END: begin
        if (!dec_r) begin
          res_emit  = 1'b1;
          res_match = !end_fail;
        end
      end
      default: begin
      end
    endcase
    if (res_emit) begin
      dec_nxt = 1'b1;
    end
  end

  // length to the fixed result width, saturating
  if (LENGTH_BITS > OUT_LEN_W) begin : g_sat
    assign len_out = (|cnt_sel[LENGTH_BITS-1:OUT_LEN_W]) ? '1 : cnt_sel[OUT_LEN_W-1:0];
  end else begin : g_ext
    assign len_out = OUT_LEN_W'(cnt_sel);
  end

  assign res = '{emit: res_emit, matched: res_match, length: res_match ? len_out : '0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      cnt_r <= '0;
      dec_r <= 1'b0;
    end else if (step) begin
      ptr_r <= ptr_nxt;
      cnt_r <= cnt_nxt;
      dec_r <= dec_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/greedy_char_class_sequence_matcher.sv
// Top level of the greedy character-class sequence matcher.
// Depends on gccm_pkg, gccm_cfg, gccm_class_mem and gccm_seq.
//
// Usage:
//   Input stream: in_tuser carries the beat kind (load class row, start text,
//   text character, end of text); in_tdata carries the character code and,
//   for loads, the membership row (bit e set when element e accepts it).
//   Output stream: one beat per text, out_tuser = matched,
//   out_tdata = match length (saturating, zero on failure).
//   APB port: element count at byte 0, repeat mask at byte 4 (8 when the
//   element capacity exceeds 32). Write registers only while idle.
// Timing:
//   One input beat per cycle while no result stalls the output. Each beat
//   reads the class memory at accept, the sequencer acts on the row in the
//   next cycle, and its result is then taken into the output register when
//   the sequencer stage advances. The single-port class memory and the
//   registered sequencer update set the rate of one beat per cycle.
// Reset:
//   Class rows read as empty, registers clear, and a text is implicitly
//   started. No clearing pass is needed.
// Back-pressure:
//   While a result waits on out_tready, input beats that decide nothing
//   still flow; a beat that would produce a second result holds the input.
`default_nettype none

module greedy_char_class_sequence_matcher import gccm_pkg::*; #(
  parameter int MAX_ELEMENTS = 16,
  parameter int LENGTH_BITS  = 16,
  localparam int IN_DW  = ((CHAR_W + MAX_ELEMENTS + 7) / 8) * 8,
  localparam int CFG_DW = (MAX_ELEMENTS > 32) ? 64 : 32,
  localparam int CFG_AW = (MAX_ELEMENTS > 32) ? 4 : 3,
  localparam int PW     = $clog2(MAX_ELEMENTS + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input stream
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [IN_DW-1:0]            in_tdata,   // [7:0] char_code, then member_mask
  input  wire logic [1:0]                  in_tuser,   // [1:0] action
  // result stream
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [OUT_LEN_W-1:0]        out_tdata,  // [15:0] match_length
  output logic                             out_tuser,  // [0] matched
  // configuration
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [CFG_AW-1:0]           cfg_paddr,
  input  wire logic [CFG_DW-1:0]           cfg_pwdata,
  output logic      [CFG_DW-1:0]           cfg_prdata,
  output logic                             cfg_pready
);

  logic                    in_acc;
  action_t                 in_act;
  logic [CHAR_W-1:0]       in_char;
  logic [MAX_ELEMENTS-1:0] in_mask;
  logic [PW-1:0]           elem_count;
  logic [MAX_ELEMENTS-1:0] repeat_mask;
  logic [MAX_ELEMENTS-1:0] row;
  logic                    s1_valid_r;
  action_t                 s1_act_r;
  seq_res_t                res;
  logic                    advance;
  logic                    out_valid_r;
  logic                    out_match_r;
  logic [OUT_LEN_W-1:0]    out_len_r;

  assign in_act  = action_t'(in_tuser);
  assign in_char = in_tdata[CHAR_W-1:0];
  assign in_mask = in_tdata[CHAR_W +: MAX_ELEMENTS];
  assign in_acc  = in_tvalid & in_tready;

  assign cfg_pready = 1'b1;

  gccm_cfg #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .elem_count  (elem_count),
    .repeat_mask (repeat_mask)
  );

  gccm_class_mem #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (in_acc),
    .wr_en (in_acc && (in_act == ACT_LOAD)),
    .addr  (in_char),
    .wdata (in_mask),
    .row   (row)
  );

  gccm_seq #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_valid_r && advance),
    .action      (s1_act_r),
    .row         (row),
    .elem_count  (elem_count),
    .repeat_mask (repeat_mask),
    .res         (res)
  );

  // sequencer stage stalls only when it has a result and the output is full
  assign advance   = !(res.emit && out_valid_r && !out_tready);
  assign in_tready = !s1_valid_r || advance;

  // sequencer stage occupancy (row data sits in the memory read register)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_act_r   <= ACT_LOAD;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
      s1_act_r   <= in_act;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && advance && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && advance && res.emit) begin
      out_match_r <= res.matched;
      out_len_r   <= res.length;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_match_r;
  assign out_tdata  = out_len_r;

  // a held sequencer beat means the output is occupied and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |-> (out_valid_r && !out_tready))
    else $error("sequencer stalled without output back-pressure");

  // only text characters and end marks decide a text
  a_emit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && res.emit) |-> ((s1_act_r == ACT_CHAR) || (s1_act_r == ACT_END)))
    else $error("result from a load or start beat");

  // a failed match reports zero length
  a_fail_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_match_r) |-> (out_len_r == '0))
    else $error("nonzero length on failed match");

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for greedy_char_class_sequence_matcher.
// Drives class loads, texts and APB register writes, and predicts each verdict.
// Depends on gccm_pkg and the matcher RTL only.
`default_nettype none

module tb;
  import gccm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ELEMENTS  = 16;
  localparam int IN_DW         = 24;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 6;
  localparam int ITEMS_PER_SET = 520;
  localparam int LONG_RUN      = 120;

  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_B    = 8'h62;
  localparam logic [7:0] CH_C    = 8'h63;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_LOW  = 8'h00;
  localparam logic [7:0] CH_HIGH = 8'hFF;

  typedef struct packed {
    logic        matched;
    logic [15:0] length;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_DW-1:0] in_tdata = '0;    // [7:0] char_code, [23:8] member_mask
  logic [1:0]       in_tuser = '0;    // [1:0] action

  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [15:0]      out_tdata;        // [15:0] match_length
  logic             out_tuser;        // [0] matched

  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // Matcher shadow state
  logic [15:0] class_row [256];
  int          elem_ptr;
  logic [15:0] match_len;
  bit          decided;
  int          elem_count;
  logic [15:0] rep_mask;

  verdict_t    pending_verdicts [$];
  logic [7:0]  loaded_chars [$];
  int          fail_count = 0;
  int          stall_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          sent_items = 0;

  greedy_char_class_sequence_matcher i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #1 clk = ~clk;

  // Shadow state after reset: empty rows, zero registers, text open
  initial begin
    for (int i = 0; i < 256; i++) class_row[i] = '0;
    elem_ptr   = 0;
    match_len  = '0;
    decided    = 1'b0;
    elem_count = 0;
    rep_mask   = '0;
  end

  function automatic void bump_length();
    if (match_len != 16'hFFFF) match_len++;
  endfunction

  // Advance the shadow matcher by one accepted beat; queue the verdict it gives
  function automatic void advance_matcher(action_t act, logic [7:0] ch, logic [15:0] mask);
    logic [15:0] row;
    bit          done;
    bit          give;
    bit          ok;
    give = 1'b0;
    ok   = 1'b0;
    case (act)
      ACT_LOAD: class_row[ch] = mask;
      ACT_START: begin
        elem_ptr  = 0;
        match_len = '0;
        decided   = 1'b0;
      end
      ACT_CHAR: if (!decided) begin
        row  = class_row[ch];
        done = 1'b0;
        while (!done && elem_ptr < elem_count) begin
          if (rep_mask[elem_ptr]) begin
            // greedy repeat: stay on a hit, skip on a miss
            if (row[elem_ptr]) begin
              bump_length();
              done = 1'b1;
            end else begin
              elem_ptr++;
            end
          end else begin
            done = 1'b1;
            give = 1'b1;
            if (row[elem_ptr]) begin
              bump_length();
              elem_ptr++;
              ok   = 1'b1;
              give = (elem_ptr >= elem_count);
            end
          end
        end
        // ran off the pattern without consuming
        if (!done) begin
          give = 1'b1;
          ok   = 1'b1;
        end
      end
      ACT_END: if (!decided) begin
        give = 1'b1;
        ok   = 1'b1;
        for (int e = elem_ptr; e < elem_count; e++) if (!rep_mask[e]) ok = 1'b0;
      end
      default: ;
    endcase
    if (give) begin
      decided = 1'b1;
      pending_verdicts.push_back('{matched: ok, length: ok ? match_len : 16'h0000});
    end
  endfunction

  // Input side: predict on every accepted beat
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      advance_matcher(action_t'(in_tuser), in_tdata[7:0], in_tdata[23:8]);
  end

  // Result side: compare each accepted beat with the oldest verdict
  always @(posedge clk) begin : check_results
    verdict_t got;
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{matched: out_tuser, length: out_tdata};
      if (pending_verdicts.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result beat: matched=%0d length=%0d", got.matched, got.length);
      end else begin
        want = pending_verdicts.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("verdict mismatch: expected matched=%0d length=%0d, got matched=%0d length=%0d",
                     want.matched, want.length, got.matched, got.length);
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Send one beat, with random sender gaps ahead of it
  task automatic send_beat(action_t act, logic [7:0] ch, logic [15:0] mask);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {mask, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_char(logic [7:0] ch);
    send_beat(ACT_CHAR, ch, 16'($urandom));
  endtask

  // Drop valid, wait for every verdict, then let the pipeline drain
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup, access, then back to idle
  task automatic write_reg(logic reg_sel, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    if (reg_sel == REG_ELEMENT_COUNT)
      elem_count = (value > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(value);
    else
      rep_mask = value[15:0];
  endtask

  task automatic set_pattern(int count, logic [15:0] mask);
    write_reg(REG_ELEMENT_COUNT, 32'(count));
    write_reg(REG_REPEAT_MASK, {16'h0000, mask});
  endtask

  task automatic load_row(logic [7:0] ch, logic [15:0] mask);
    send_beat(ACT_LOAD, ch, mask);
  endtask

  // No start after reset, empty pattern, ignored beats once decided
  task automatic test_after_reset();
    send_char(CH_LOW);
    send_char(CH_HIGH);
    send_beat(ACT_END, CH_LOW, 16'hFFFF);
    send_beat(ACT_START, CH_HIGH, 16'h0000);
    send_beat(ACT_END, CH_HIGH, 16'h0000);
    settle();
  endtask

  // Pattern a b* c: literals, a star, failure, early end
  task automatic test_literal_star();
    set_pattern(3, 16'h0002);
    load_row(CH_A, 16'h0001);
    load_row(CH_B, 16'h0002);
    load_row(CH_C, 16'h0004);
    load_row(CH_HIGH, 16'hFFFF);
    send_beat(ACT_START, CH_LOW, '0);
    send_char(CH_A);
    send_char(CH_B);
    send_char(CH_B);
    send_char(CH_C);
    send_beat(ACT_START, CH_LOW, '0);
    send_char(CH_A);
    send_char(CH_C);
    send_beat(ACT_START, CH_LOW, '0);
    send_char(CH_A);
    send_char(CH_X);
    send_beat(ACT_START, CH_LOW, '0);
    send_char(CH_A);
    send_char(CH_B);
    send_beat(ACT_END, CH_LOW, '0);
    settle();
  endtask

  // All elements repeat: end succeeds, unmatched char ends the pattern
  task automatic test_all_repeat();
    set_pattern(2, 16'h0003);
    send_beat(ACT_START, CH_LOW, '0);
    send_char(CH_A);
    send_beat(ACT_END, CH_LOW, '0);
    send_beat(ACT_START, CH_LOW, '0);
    send_char(CH_A);
    send_char(CH_C);
    send_beat(ACT_START, CH_LOW, '0);
    send_beat(ACT_END, CH_LOW, '0);
    settle();
  endtask

  // Oversized count, full and empty repeat masks
  task automatic test_extremes();
    set_pattern(31, 16'hFFFF);
    send_beat(ACT_START, CH_LOW, '0);
    repeat (3) send_char(CH_HIGH);
    send_beat(ACT_END, CH_LOW, '0);
    settle();
    set_pattern(MAX_ELEMENTS, 16'h0000);
    send_beat(ACT_START, CH_LOW, '0);
    repeat (MAX_ELEMENTS) send_char(CH_HIGH);
    settle();
  endtask

  // Shrink the pattern under an open text
  task automatic test_midtext_change();
    set_pattern(3, 16'h0000);
    send_beat(ACT_START, CH_LOW, '0);
    send_char(CH_HIGH);
    send_char(CH_HIGH);
    settle();
    write_reg(REG_ELEMENT_COUNT, 32'd1);
    send_char(CH_HIGH);
    settle();
  endtask

  // Length counting on one long star run
  task automatic test_long_star_run();
    set_pattern(1, 16'h0001);
    load_row(CH_X, 16'h0001);
    send_beat(ACT_START, CH_LOW, '0);
    repeat (LONG_RUN) send_char(CH_X);
    send_beat(ACT_END, CH_LOW, '0);
    settle();
  endtask

  // A character that element e accepts, or now and then any character
  function automatic logic [7:0] pick_member(int e);
    logic [7:0] c;
    if ($urandom_range(99) >= 12 && loaded_chars.size() != 0) begin
      for (int t = 0; t < 16; t++) begin
        c = loaded_chars[$urandom_range(loaded_chars.size() - 1)];
        if (class_row[c][e]) return c;
      end
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [15:0] random_row();
    case ($urandom_range(2))
      0:       return 16'($urandom);
      1:       return 16'($urandom & $urandom);
      default: return (16'h1 << $urandom_range(15)) | (16'h1 << $urandom_range(15));
    endcase
  endfunction

  // New pattern and a fresh set of class rows
  task automatic random_pattern();
    int          count;
    logic [15:0] mask;
    logic [7:0]  ch;
    case ($urandom_range(19))
      0:       count = 0;
      1, 2:    count = MAX_ELEMENTS;
      3:       count = $urandom_range(31, MAX_ELEMENTS + 1);
      default: count = $urandom_range(8, 1);
    endcase
    case ($urandom_range(9))
      0:       mask = 16'h0000;
      1:       mask = 16'hFFFF;
      default: mask = 16'($urandom);
    endcase
    set_pattern(count, mask);
    loaded_chars.delete();
    repeat (12) begin
      ch = 8'($urandom_range(255));
      loaded_chars.push_back(ch);
      load_row(ch, random_row());
    end
  endtask

  // One text built along the pattern, with noise and broken endings
  task automatic random_text();
    int reps;
    if ($urandom_range(19) != 0) send_beat(ACT_START, 8'($urandom), 16'($urandom));
    for (int e = 0; e < elem_count; e++) begin
      reps = rep_mask[e] ? $urandom_range(3) : 1;
      repeat (reps) send_char(pick_member(e));
      if ($urandom_range(39) == 0) load_row(8'($urandom_range(255)), random_row());
    end
    case ($urandom_range(9))
      0, 1: ;
      2, 3: begin
        repeat ($urandom_range(3, 1)) send_char(8'($urandom_range(255)));
        send_beat(ACT_END, 8'($urandom), 16'($urandom));
      end
      default: send_beat(ACT_END, 8'($urandom), 16'($urandom));
    endcase
  endtask

  task automatic test_random(int send_pct, int recv_pct);
    int first_item;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first_item = sent_items;
    while (sent_items - first_item < ITEMS_PER_SET) begin
      settle();
      random_pattern();
      repeat (8) random_text();
    end
    settle();
  endtask

  initial begin
    send_idle_pct = 27;
    recv_idle_pct = 55;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_after_reset();
    test_literal_star();
    test_all_repeat();
    test_extremes();
    test_midtext_change();
    test_random(27, 55);
    test_random(55, 27);
    test_random(0, 0);
    test_long_star_run();

    fail_count += pending_verdicts.size();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
